// ===== rtl/wsdf_pkg.sv =====
// ---------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared types and constants for the frame header decoder and its top level.
// ---------------------------------------------------------------------------
package wsdf_pkg;

	// Width of the kept payload length (16 to 32)
	localparam int LENGTH_BITS = 32;

	// Second header byte length codes
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Extension and key byte counts
	localparam logic [3:0] EXT16_BYTES    = 4'd2;
	localparam logic [3:0] EXT64_SKIP     = 4'd4;
	localparam logic [3:0] EXT64_BYTES    = 4'd8;
	localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

	// Decoder phases, one-hot
	typedef enum logic [6:0] {
		PH_HDR0    = 7'b0000001,
		PH_HDR1    = 7'b0000010,
		PH_EXT16   = 7'b0000100,
		PH_EXT64   = 7'b0001000,
		PH_MASK    = 7'b0010000,
		PH_PAYLOAD = 7'b0100000,
		PH_DRAIN   = 7'b1000000
	} phase_t;

	// Frame decoder state
	typedef struct packed {
		phase_t                 phase;
		logic [3:0]             hdr_idx;
		logic [3:0]             opcode;
		logic                   mask_on;
		logic [LENGTH_BITS-1:0] length;
		logic [31:0]            key;
		logic [LENGTH_BITS-1:0] count;
	} state_t;

	// One result transaction
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic [3:0]  opcode;
		logic [31:0] length;
		logic        frame_end;
		logic        status;
	} result_t;

endpackage

// ===== rtl/wsdf_step.sv =====
// ---------------------------------------------------------------------------
// WebSocket frame deframer byte step
// Combinational next-state and result logic for one received byte.
// ---------------------------------------------------------------------------
module wsdf_step (
	input  wsdf_pkg::state_t  cur,
	input  logic [7:0]        data_byte,
	input  logic              last,
	output wsdf_pkg::state_t  nxt,
	output wsdf_pkg::result_t res,
	output logic              has_res
);
	import wsdf_pkg::*;

	logic       hdr_done;
	logic       start;
	logic       done;
	logic       have_byte;
	logic       drop;
	logic [7:0] ob;
	logic [3:0] idx_inc;

	assign idx_inc = cur.hdr_idx + 4'd1;

	always_comb begin
		nxt       = cur;
		hdr_done  = 1'b0;
		start     = 1'b0;
		done      = 1'b0;
		have_byte = 1'b0;
		drop      = 1'b0;
		ob        = 8'h00;

		// per-phase byte handling
		case (cur.phase)
			PH_HDR0: begin
				nxt.opcode  = data_byte[3:0];
				nxt.mask_on = 1'b0;
				nxt.length  = '0;
				nxt.key     = '0;
				nxt.count   = '0;
				nxt.hdr_idx = '0;
				nxt.phase   = PH_HDR1;
			end
			PH_HDR1: begin
				nxt.mask_on = data_byte[7];
				nxt.hdr_idx = '0;
				if (data_byte[6:0] == LEN_EXT16) begin
					nxt.phase = PH_EXT16;
				end else if (data_byte[6:0] == LEN_EXT64) begin
					nxt.phase = PH_EXT64;
				end else begin
					nxt.length = LENGTH_BITS'(data_byte[6:0]);
					hdr_done   = 1'b1;
				end
			end
			PH_EXT16: begin
				nxt.length  = LENGTH_BITS'({cur.length, data_byte});
				nxt.hdr_idx = idx_inc;
				if (idx_inc >= EXT16_BYTES) begin
					hdr_done = 1'b1;
				end
			end
			PH_EXT64: begin
				// only the low four bytes of the 64-bit length count
				if (cur.hdr_idx >= EXT64_SKIP) begin
					nxt.length = LENGTH_BITS'({cur.length, data_byte});
				end
				nxt.hdr_idx = idx_inc;
				if (idx_inc >= EXT64_BYTES) begin
					hdr_done = 1'b1;
				end
			end
			PH_MASK: begin
				nxt.key     = {cur.key[23:0], data_byte};
				nxt.hdr_idx = idx_inc;
				if (idx_inc >= MASK_KEY_BYTES) begin
					nxt.hdr_idx = '0;
					start       = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				// key byte 0 is the most significant
				ob        = data_byte ^ cur.key[8*(3 - int'(cur.count[1:0])) +: 8];
				nxt.count = cur.count + LENGTH_BITS'(1);
				have_byte = 1'b1;
				if (nxt.count == cur.length) begin
					done = 1'b1;
				end
			end
			PH_DRAIN: begin
				drop = 1'b1;
				if (last) begin
					nxt.phase = PH_HDR0;
				end
			end
			default: begin
				drop = 1'b1;
				if (last) begin
					nxt.phase = PH_HDR0;
				end
			end
		endcase

		// header complete: key next, or payload
		if (hdr_done) begin
			nxt.hdr_idx = '0;
			if (nxt.mask_on) begin
				nxt.phase = PH_MASK;
			end else begin
				start = 1'b1;
			end
		end
		if (start) begin
			nxt.count = '0;
			if (nxt.length == '0) begin
				done = 1'b1;
			end else begin
				nxt.phase = PH_PAYLOAD;
			end
		end

		// result selection
		has_res        = 1'b0;
		res.out_byte   = 8'h00;
		res.byte_valid = 1'b0;
		res.opcode     = nxt.opcode;
		res.length     = 32'(nxt.length);
		res.frame_end  = 1'b0;
		res.status     = 1'b0;
		if (!drop) begin
			if (done) begin
				has_res        = 1'b1;
				res.out_byte   = ob;
				res.byte_valid = have_byte;
				res.frame_end  = 1'b1;
				nxt.phase      = last ? PH_HDR0 : PH_DRAIN;
			end else if (last) begin
				// buffer ended early: incomplete marker
				has_res       = 1'b1;
				res.frame_end = 1'b1;
				res.status    = 1'b1;
				nxt.phase     = PH_HDR0;
			end else if (have_byte) begin
				has_res        = 1'b1;
				res.out_byte   = ob;
				res.byte_valid = 1'b1;
			end
		end
	end

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// Flow: a byte accepted into the input register is decoded combinationally, and its result
// enters the result register when the byte moves on, which a receiver stall can hold off.
// Throughput: one byte per cycle while the receiver does not stall; a byte with no result is still consumed.
// The input register and the result register decouple the two channels.
// Reset (arst_n low) clears all valid flags and the decoder state at once;
// the block waits for the first header byte of a new frame.
// ---------------------------------------------------------------------------
// WebSocket frame deframer
// Decodes one WebSocket frame per received buffer, one byte per transaction,
// and emits unmasked payload bytes plus end and incomplete markers.
// ---------------------------------------------------------------------------
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic [3:0]  frame_opcode,
	output logic [31:0] decoded_length,
	output logic        frame_end,
	output logic        status
);
	import wsdf_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       end_s1;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res;
	result_t    res_q;
	logic       has_res;
	logic       advance;

	// a held byte moves on when the result slot is free or being taken
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			end_s1  <= buffer_end;
		end
	end

	// byte decode
	wsdf_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.last      (end_s1),
		.nxt       (state_nxt),
		.res       (res),
		.has_res   (has_res)
	);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= PH_HDR0;
			state_q.hdr_idx <= '0;
			state_q.opcode  <= '0;
			state_q.mask_on <= 1'b0;
			state_q.length  <= '0;
			state_q.key     <= '0;
			state_q.count   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= has_res;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_q <= res;
		end
	end

	assign out_byte       = res_q.out_byte;
	assign byte_valid     = res_q.byte_valid;
	assign frame_opcode   = res_q.opcode;
	assign decoded_length = res_q.length;
	assign frame_end      = res_q.frame_end;
	assign status         = res_q.status;

	// a result without frame end always carries a payload byte
	a_mid_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> byte_valid)
		else $error("mid-frame result without payload byte");

	// incomplete marker ends the frame and carries no byte
	a_status_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> frame_end && !byte_valid)
		else $error("incomplete marker malformed");

	// markers carry a zero byte
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'h00)
		else $error("marker result with nonzero byte");

	// decoder state only moves when a held byte is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("decoder state changed without a byte");

	// an incomplete marker always returns the decoder to the header phase
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_res && res.status |=> state_q.phase == PH_HDR0)
		else $error("no restart after incomplete frame");

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds received buffers byte by byte, predicts the frame decoder's results
// in a scoreboard and compares every output transaction field by field.
// A short directed set covers one-byte buffers, empty masked frames, 16-bit
// and 64-bit extended lengths, trailing bytes and an early buffer end. The
// random part is mostly well-formed frames, whole or cut short, plus noise.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wsdf_pkg::*;

	localparam int          RANDOM_ITEMS = 1650;
	localparam int          IDLE_LIMIT   = 2000;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          MAX_REPORTS  = 10;
	localparam logic [63:0] LEN_MASK     = (64'd1 << LENGTH_BITS) - 64'd1;

	// Frame decoder predictor and store of decoded results
	class frame_scoreboard;
		phase_t      phase;
		logic [3:0]  hdr_idx;
		logic [3:0]  opcode;
		logic        mask_on;
		logic [31:0] length;
		logic [31:0] key;
		logic [31:0] count;
		result_t     decoded_q[$];
		int          mismatches;
		int          checked;
		int          payload_bytes;
		int          empty_frames;
		int          cut_frames;
		int          dropped;

		function new();
			phase      = PH_HDR0;
			hdr_idx    = '0;
			opcode     = '0;
			mask_on    = 1'b0;
			length     = '0;
			key        = '0;
			count      = '0;
			mismatches = 0;
			checked    = 0;
			payload_bytes = 0;
			empty_frames  = 0;
			cut_frames    = 0;
			dropped       = 0;
		endfunction

		function void push_result(logic [7:0] ob, logic bv, logic fe, logic st);
			result_t r;
			r.out_byte   = ob;
			r.byte_valid = bv;
			r.opcode     = opcode;
			r.length     = length;
			r.frame_end  = fe;
			r.status     = st;
			decoded_q.push_back(r);
		endfunction

		// One accepted byte; returns 0 when the byte is dropped after a frame
		function bit note_byte(logic [7:0] b, logic last);
			bit         hdr_done;
			bit         start;
			bit         done;
			bit         have_byte;
			logic [7:0] ob;
			int         k;
			hdr_done  = 0;
			start     = 0;
			done      = 0;
			have_byte = 0;
			ob        = 8'h00;
			case (phase)
				PH_HDR0: begin
					opcode  = b[3:0];
					mask_on = 1'b0;
					length  = '0;
					key     = '0;
					count   = '0;
					hdr_idx = '0;
					phase   = PH_HDR1;
				end
				PH_HDR1: begin
					mask_on = b[7];
					hdr_idx = '0;
					if (b[6:0] == LEN_EXT16) begin
						phase = PH_EXT16;
					end else if (b[6:0] == LEN_EXT64) begin
						phase = PH_EXT64;
					end else begin
						length   = 32'(64'(b[6:0]) & LEN_MASK);
						hdr_done = 1;
					end
				end
				PH_EXT16: begin
					length  = 32'(((64'(length) << 8) | 64'(b)) & LEN_MASK);
					hdr_idx = hdr_idx + 4'd1;
					if (hdr_idx >= EXT16_BYTES)
						hdr_done = 1;
				end
				PH_EXT64: begin
					// upper four bytes of the 64-bit length are skipped
					if (hdr_idx >= EXT64_SKIP)
						length = 32'(((64'(length) << 8) | 64'(b)) & LEN_MASK);
					hdr_idx = hdr_idx + 4'd1;
					if (hdr_idx >= EXT64_BYTES)
						hdr_done = 1;
				end
				PH_MASK: begin
					key     = {key[23:0], b};
					hdr_idx = hdr_idx + 4'd1;
					if (hdr_idx >= MASK_KEY_BYTES) begin
						hdr_idx = '0;
						start   = 1;
					end
				end
				PH_PAYLOAD: begin
					k         = int'(count[1:0]);
					ob        = b ^ 8'(key >> (8 * (3 - k)));
					count     = count + 32'd1;
					have_byte = 1;
					if (count == length)
						done = 1;
				end
				default: begin
					// trailing bytes after the frame
					dropped++;
					if (last)
						phase = PH_HDR0;
					return 0;
				end
			endcase

			if (hdr_done) begin
				hdr_idx = '0;
				if (mask_on)
					phase = PH_MASK;
				else
					start = 1;
			end
			if (start) begin
				count = '0;
				if (length == 32'd0)
					done = 1;
				else
					phase = PH_PAYLOAD;
			end

			if (done) begin
				push_result(ob, have_byte, 1'b1, 1'b0);
				if (!have_byte)
					empty_frames++;
				phase = last ? PH_HDR0 : PH_DRAIN;
			end else if (last) begin
				// buffer ended before the frame did
				push_result(8'h00, 1'b0, 1'b1, 1'b1);
				cut_frames++;
				phase = PH_HDR0;
			end else if (have_byte) begin
				push_result(ob, 1'b1, 1'b0, 1'b0);
			end
			if (have_byte)
				payload_bytes++;
			return 1;
		endfunction

		// One accepted result against the oldest decoded result
		function void check_result(result_t got);
			result_t want;
			checked++;
			if (decoded_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: byte=%h v=%b op=%h len=%h end=%b st=%b",
						got.out_byte, got.byte_valid, got.opcode, got.length,
						got.frame_end, got.status);
				return;
			end
			want = decoded_q.pop_front();
			if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
					got.opcode !== want.opcode || got.length !== want.length ||
					got.frame_end !== want.frame_end || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch at %0t: expected byte=%h v=%b op=%h len=%h end=%b st=%b",
						$realtime, want.out_byte, want.byte_valid, want.opcode,
						want.length, want.frame_end, want.status);
					$display("                 actual   byte=%h v=%b op=%h len=%h end=%b st=%b",
						got.out_byte, got.byte_valid, got.opcode, got.length,
						got.frame_end, got.status);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        buffer_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic [3:0]  frame_opcode;
	logic [31:0] decoded_length;
	logic        frame_end;
	logic        status;

	frame_scoreboard sb = new();
	logic [7:0]      rx_bytes[$];
	bit              idle_on = 0;
	int              stall_left = 0;
	int              idle_cycles = 0;
	int              bytes_sent = 0;
	int              buffers_sent = 0;

	websocket_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.buffer_end    (buffer_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.frame_opcode  (frame_opcode),
		.decoded_length(decoded_length),
		.frame_end     (frame_end),
		.status        (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			int hold;
			hold = idle_on ? gap_len() : 0;
			out_stall  <= (hold > 0);
			stall_left <= (hold > 0) ? hold - 1 : 0;
		end
	end

	// Result check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_t'({out_byte, byte_valid, frame_opcode, decoded_length,
				frame_end, status}));
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Send one byte, with an optional gap before it
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		@(negedge clk);
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		buffer_end <= last;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		void'(sb.note_byte(b, last));
	endtask

	task automatic send_buffer();
		foreach (rx_bytes[i])
			send_byte(rx_bytes[i], i == rx_bytes.size() - 1);
		buffers_sent++;
	endtask

	// Hold off the sender until every decoded result has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.decoded_q.size() != 0)
			@(posedge clk);
	endtask

	// Random buffer: mostly a well-formed frame, whole or cut, else noise
	task automatic build_buffer();
		int              sel;
		int              n;
		bit              mask;
		bit              whole;
		logic [15:0]     len16;
		logic [31:0]     len_hi;
		logic [31:0]     len_lo;
		int unsigned     plen;
		longint          full_len;
		longint          target;
		rx_bytes.delete();
		if ($urandom_range(0, 99) < 10) begin
			n = $urandom_range(1, 12);
			repeat (n) rx_bytes.push_back(8'($urandom));
			return;
		end
		mask = 1'($urandom);
		rx_bytes.push_back(8'($urandom));
		sel = $urandom_range(0, 99);
		if (sel < 65) begin
			plen = (sel < 50) ? $urandom_range(0, 12) : $urandom_range(0, 125);
			rx_bytes.push_back({mask, 7'(plen)});
		end else if (sel < 83) begin
			len16 = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 40)) : 16'($urandom);
			rx_bytes.push_back({mask, LEN_EXT16});
			rx_bytes.push_back(len16[15:8]);
			rx_bytes.push_back(len16[7:0]);
			plen = len16;
		end else begin
			len_hi = $urandom;
			len_lo = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 40) : $urandom;
			rx_bytes.push_back({mask, LEN_EXT64});
			for (int i = 3; i >= 0; i--)
				rx_bytes.push_back(len_hi[8 * i +: 8]);
			for (int i = 3; i >= 0; i--)
				rx_bytes.push_back(len_lo[8 * i +: 8]);
			plen = len_lo;
		end
		if (mask)
			repeat (4) rx_bytes.push_back(8'($urandom));

		full_len = longint'(rx_bytes.size()) + longint'(plen);
		whole = ($urandom_range(0, 99) < 75) && (plen <= 200);
		if (whole) begin
			repeat (plen) rx_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 99) < 30) begin
				n = $urandom_range(1, 3);
				repeat (n) rx_bytes.push_back(8'($urandom));
			end
		end else begin
			// end the buffer before the frame is complete, at most 40 bytes past the header
			target = full_len - 1;
			if (target > rx_bytes.size() + 40)
				target = rx_bytes.size() + 40;
			target = $urandom_range(1, int'(target));
			while (rx_bytes.size() > target)
				void'(rx_bytes.pop_back());
			while (rx_bytes.size() < target)
				rx_bytes.push_back(8'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: one-byte buffer
		rx_bytes = '{8'h0F};
		send_buffer();
		// empty masked frame, buffer ends on the last key byte
		rx_bytes = '{8'h80, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44};
		send_buffer();
		// 16-bit length, masked, one payload byte, one trailing byte
		rx_bytes = '{8'hF9, 8'hFE, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hA5};
		send_buffer();
		// 64-bit length with nonzero upper bytes, last byte ends the buffer
		rx_bytes = '{8'h0A, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
			8'hFF};
		send_buffer();
		// buffer ends on a payload byte of a longer frame
		rx_bytes = '{8'h02, 8'h7D, 8'h5A};
		send_buffer();
		wait_drained();

		// Random frames until the byte budget is spent; idling off in some stretches
		while (bytes_sent < RANDOM_ITEMS) begin
			if (buffers_sent % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (buffers_sent % 60 == 0)
				wait_drained();
			build_buffer();
			send_buffer();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.decoded_q.size() != 0)
			$display("%0d results never came out", sb.decoded_q.size());
		$display("covered %0d buffers, %0d bytes in, %0d dropped after frame end",
			buffers_sent, bytes_sent, sb.dropped);
		$display("checked %0d results: %0d payload bytes, %0d empty frames, %0d cut frames",
			sb.checked, sb.payload_bytes, sb.empty_frames, sb.cut_frames);
		if (sb.mismatches == 0 && sb.decoded_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
